[hw/rtl/ifp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types, codes and scaling function for the IMU frame parser.
// ----------------------------------------------------------------------------
package ifp_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN_DEF = 11;
    localparam logic [7:0]  HDR_BYTE      = 8'h55;
    localparam logic [7:0]  TYPE_RATE     = 8'h52;
    localparam logic [7:0]  TYPE_ANGLE    = 8'h53;

    // Result kind codes
    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    // Q.8 scaling: rate = floor(w*125/8), angle = floor(w*45/32)
    localparam int unsigned      WORD_W    = 16;
    localparam int unsigned      MUL_W     = 8;
    localparam int unsigned      PROD_W    = WORD_W + MUL_W;
    localparam int unsigned      OUT_W     = 20;
    localparam logic signed [MUL_W-1:0] RATE_MUL  = 8'sd125;
    localparam logic signed [MUL_W-1:0] ANGLE_MUL = 8'sd45;
    localparam int unsigned      RATE_SH   = 3;
    localparam int unsigned      ANGLE_SH  = 5;

    // One complete frame of a known type
    typedef struct packed {
        logic                     kind;
        logic signed [WORD_W-1:0] roll;
        logic signed [WORD_W-1:0] yaw;
        logic signed [WORD_W-1:0] pitch;
    } frame_t;

    // Multiply by the kind's factor and shift right arithmetically (floor)
    function automatic logic signed [OUT_W-1:0] scale_q8(
        input logic signed [WORD_W-1:0] w,
        input logic                     kind
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] quot;
        if (kind == KIND_ANGLE)
        begin
            prod = w * ANGLE_MUL;
            quot = prod >>> ANGLE_SH;
        end
        else
        begin
            prod = w * RATE_MUL;
            quot = prod >>> RATE_SH;
        end
        return quot[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/imu_frame_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// A taken final byte sends the frame through the frame register, then the
//   scaled result register. Throughput: one byte per cycle unless stalled;
//   at most one result per FRAME_LEN bytes.
// Reset (rst_n, asynchronous, active low) clears the byte count and both
//   valid flags; stored frame bytes are left as they are.
// ----------------------------------------------------------------------------
// imu_frame_parser_top
// Fixed-length serial frame parser for an inertial sensor: rate and angle
// frames in, three Q.8 axis values out.
// ----------------------------------------------------------------------------
module imu_frame_parser_top #(
    parameter int unsigned FRAME_LEN = ifp_pkg::FRAME_LEN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   kind,
    output logic signed [ifp_pkg::OUT_W-1:0]       roll,
    output logic signed [ifp_pkg::OUT_W-1:0]       yaw,
    output logic signed [ifp_pkg::OUT_W-1:0]       pitch
);

    logic            frm_valid;
    logic            frm_ready;
    ifp_pkg::frame_t frm;

    // Header hunt and frame capture
    ifp_framer #(
        .FRAME_LEN (FRAME_LEN)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    // Scaling and result register
    ifp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .roll      (roll),
        .yaw       (yaw),
        .pitch     (pitch)
    );

endmodule
`default_nettype wire

[hw/rtl/ifp_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_framer
// Header hunt, byte counting and frame capture; emits one registered frame
// for each completed frame of rate or angle type.
// ----------------------------------------------------------------------------
module ifp_framer #(
    parameter int unsigned FRAME_LEN = ifp_pkg::FRAME_LEN_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     rx_byte,
    output logic                frm_valid,
    input  wire logic           frm_ready,
    output ifp_pkg::frame_t     frm
);

    localparam int unsigned CW       = $clog2(FRAME_LEN);
    localparam int unsigned FIRST_DB = 1;   // type byte
    localparam int unsigned LAST_DB  = 7;   // high byte of yaw

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [7:0]     bytes_reg [FIRST_DB:LAST_DB];
    logic [7:0]     view      [FIRST_DB:LAST_DB];
    logic           frm_valid_reg;
    logic           frm_valid_next;
    ifp_pkg::frame_t frm_reg;
    ifp_pkg::frame_t frm_next;
    logic           accept;
    logic           drop;
    logic           last;
    logic           known;

    // Handshake
    assign in_ready  = !frm_valid_reg || frm_ready;
    assign accept    = in_valid && in_ready;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    // Header hunt and end of frame
    assign drop = (count_reg == '0) && (rx_byte != ifp_pkg::HDR_BYTE);
    assign last = (count_reg == CW'(FRAME_LEN - 1));

    // Frame view with the incoming byte bypassed into its slot
    always_comb
    begin
        for (int i = FIRST_DB; i <= LAST_DB; i++)
        begin
            view[i] = (count_reg == CW'(i)) ? rx_byte : bytes_reg[i];
        end
    end

    // Type decode and word assembly
    always_comb
    begin
        frm_next.pitch = {view[3], view[2]};
        frm_next.roll  = {view[5], view[4]};
        frm_next.yaw   = {view[7], view[6]};
        unique case (view[1])
            ifp_pkg::TYPE_RATE:
            begin
                known         = 1'b1;
                frm_next.kind = ifp_pkg::KIND_RATE;
            end
            ifp_pkg::TYPE_ANGLE:
            begin
                known         = 1'b1;
                frm_next.kind = ifp_pkg::KIND_ANGLE;
            end
            default:
            begin
                known         = 1'b0;
                frm_next.kind = ifp_pkg::KIND_RATE;
            end
        endcase
    end

    // Next count and frame valid
    always_comb
    begin
        count_next     = count_reg;
        frm_valid_next = frm_valid_reg && !frm_ready;
        if (accept && !drop)
        begin
            if (last)
            begin
                count_next = '0;
                if (known)
                begin
                    frm_valid_next = 1'b1;
                end
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    // Data byte store and frame register
    always_ff @(posedge clk)
    begin
        for (int i = FIRST_DB; i <= LAST_DB; i++)
        begin
            if (accept && (count_reg == CW'(i)))
            begin
                bytes_reg[i] <= rx_byte;
            end
        end
        if (accept && !drop && last && known)
        begin
            frm_reg <= frm_next;
        end
    end

`ifndef SYNTH
    // A non-header byte while hunting keeps the framer hunting
    a_hunt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && drop) |=> (count_reg == '0))
        else $error("ifp_framer: dropped byte advanced the count");

    // A new frame only follows the final byte of a frame
    a_frame_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frm_valid_reg && !$past(frm_valid_reg)) |->
            ($past(accept) && ($past(count_reg) == CW'(FRAME_LEN - 1))
             && (count_reg == '0)))
        else $error("ifp_framer: frame issued without a final byte");
`endif

endmodule
`default_nettype wire

[hw/rtl/ifp_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifp_scale
// Scales the three words of a frame to Q.8 and holds the result register.
// ----------------------------------------------------------------------------
module ifp_scale (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              frm_valid,
    output logic                                   frm_ready,
    input  wire ifp_pkg::frame_t                   frm,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   kind,
    output logic signed [ifp_pkg::OUT_W-1:0]       roll,
    output logic signed [ifp_pkg::OUT_W-1:0]       yaw,
    output logic signed [ifp_pkg::OUT_W-1:0]       pitch
);

    localparam int ANGLE_MAX = 46080;   // 32768 * 45 / 32

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                kind_reg;
    logic signed [ifp_pkg::OUT_W-1:0]    roll_reg;
    logic signed [ifp_pkg::OUT_W-1:0]    yaw_reg;
    logic signed [ifp_pkg::OUT_W-1:0]    pitch_reg;
    logic                                load;

    // Handshake
    assign frm_ready = !out_valid_reg || out_ready;
    assign load      = frm_valid && frm_ready;

    assign out_valid_next = (out_valid_reg && !out_ready) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Scaling lanes into the result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= frm.kind;
            roll_reg  <= ifp_pkg::scale_q8(frm.roll,  frm.kind);
            yaw_reg   <= ifp_pkg::scale_q8(frm.yaw,   frm.kind);
            pitch_reg <= ifp_pkg::scale_q8(frm.pitch, frm.kind);
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign roll      = roll_reg;
    assign yaw       = yaw_reg;
    assign pitch     = pitch_reg;

`ifndef SYNTH
    // Angle results stay within the angle range on all three axes
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == ifp_pkg::KIND_ANGLE)) |->
            ((int'(roll_reg) >= -ANGLE_MAX) && (int'(roll_reg) < ANGLE_MAX)
             && (int'(yaw_reg) >= -ANGLE_MAX) && (int'(yaw_reg) < ANGLE_MAX)
             && (int'(pitch_reg) >= -ANGLE_MAX) && (int'(pitch_reg) < ANGLE_MAX)))
        else $error("ifp_scale: angle result out of range");

    // A taken frame is always shown on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid_reg && (kind_reg == $past(frm.kind))))
        else $error("ifp_scale: loaded frame not presented");
`endif

endmodule
`default_nettype wire

[sim/imu_frame_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser_top_test
// Self-checking bench for the IMU frame parser. A short table of directed
// frames (header search, extremes, header byte inside a frame, unknown type)
// is followed by random frames mixed with noise and truncated frames. Every
// accepted byte steps a local frame predictor; results are compared field by
// field, in order, against the predicted queue. Both handshakes idle and
// stall at random.
// ----------------------------------------------------------------------------
module imu_frame_parser_top_test;

    localparam int         FRAME_LEN   = ifp_pkg::FRAME_LEN_DEF;
    localparam int         STORE_DEPTH = 10;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam int         RATE_GAIN   = 125;
    localparam int         RATE_SHIFT  = 3;
    localparam int         ANGLE_GAIN  = 45;
    localparam int         ANGLE_SHIFT = 5;
    localparam int         RUN_ITEMS   = 1100;
    localparam int         HOLD_CYCLES = 200;
    localparam int         STALL_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 8;
    localparam int         MAX_REPORTS = 10;

    // One frame result as the block presents it
    typedef struct packed {
        logic                             kind;
        logic signed [ifp_pkg::OUT_W-1:0] roll;
        logic signed [ifp_pkg::OUT_W-1:0] yaw;
        logic signed [ifp_pkg::OUT_W-1:0] pitch;
    } axes_t;

    // How a directed row is checked on its last byte
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_GIVEN,
        ROW_SILENT
    } row_chk_t;

    typedef struct packed {
        logic [3:0]       len;
        row_chk_t         chk;
        axes_t            res;
        logic [0:10][7:0] bytes;
    } dir_row_t;

    // Directed frames, byte 0 first
    localparam dir_row_t DIR_TAB [4] = '{
        // noise before any header is dropped
        '{len: 4'd2, chk: ROW_SILENT, res: '0,
          bytes: {8'h00, 8'hFF, 72'h0}},
        // rate frame, pitch and roll at the word extremes, yaw at -1
        '{len: 4'd11, chk: ROW_GIVEN,
          res: '{kind: ifp_pkg::KIND_RATE, roll: 20'sd511984, yaw: -20'sd16,
                 pitch: -20'sd512000},
          bytes: {8'h55, 8'h52, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h3C}},
        // angle frame with header bytes inside it, also past the store
        '{len: 4'd11, chk: ROW_PREDICT, res: '0,
          bytes: {8'h55, 8'h53, 8'h55, 8'h55, 8'h00, 8'h80, 8'hFF, 8'h7F,
                  8'h55, 8'h55, 8'h55}},
        // acceleration type gives nothing
        '{len: 4'd11, chk: ROW_SILENT, res: '0,
          bytes: {8'h55, 8'h51, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC,
                  8'hDE, 8'hF0, 8'h01}}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       rx_byte;
    logic                             out_valid;
    logic                             out_ready;
    logic                             kind;
    logic signed [ifp_pkg::OUT_W-1:0] roll;
    logic signed [ifp_pkg::OUT_W-1:0] yaw;
    logic signed [ifp_pkg::OUT_W-1:0] pitch;

    // Predictor state
    logic [3:0] frm_count;
    logic [7:0] frm_store [STORE_DEPTH];

    axes_t axes_q [$];
    int    mismatches;
    int    acc_count;
    int    kept_bytes;
    int    stall_cycles;

    imu_frame_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .roll      (roll),
        .yaw       (yaw),
        .pitch     (pitch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Q.8 scaling of a little-endian word, floor division by the shift
    function automatic logic signed [ifp_pkg::OUT_W-1:0] to_q8(
        input logic [7:0] lo,
        input logic [7:0] hi,
        input logic       kind_bit
    );
        int w;
        int p;
        w = $signed({hi, lo});
        if (kind_bit == ifp_pkg::KIND_ANGLE)
            p = (w * ANGLE_GAIN) >>> ANGLE_SHIFT;
        else
            p = (w * RATE_GAIN) >>> RATE_SHIFT;
        return p[ifp_pkg::OUT_W-1:0];
    endfunction

    // Step the frame predictor by one byte; 1 when a result is due
    function automatic bit predict_frame(input logic [7:0] b, output axes_t r);
        logic k;
        r = '0;
        if (frm_count == 4'd0 && b != ifp_pkg::HDR_BYTE)
            return 1'b0;
        kept_bytes++;
        if (frm_count < STORE_DEPTH)
            frm_store[frm_count] = b;
        if (frm_count != FRAME_LEN - 1)
        begin
            frm_count++;
            return 1'b0;
        end
        frm_count = 4'd0;
        if (frm_store[1] == ifp_pkg::TYPE_RATE)
            k = ifp_pkg::KIND_RATE;
        else if (frm_store[1] == ifp_pkg::TYPE_ANGLE)
            k = ifp_pkg::KIND_ANGLE;
        else
            return 1'b0;
        r.kind  = k;
        r.roll  = to_q8(frm_store[4], frm_store[5], k);
        r.yaw   = to_q8(frm_store[6], frm_store[7], k);
        r.pitch = to_q8(frm_store[2], frm_store[3], k);
        return 1'b1;
    endfunction

    function automatic void log_mismatch(input string what, input axes_t want,
                                         input axes_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch (%s) at %0t:", what, $realtime);
            $display("  want kind %0d roll %0d yaw %0d pitch %0d",
                     want.kind, want.roll, want.yaw, want.pitch);
            $display("  got  kind %0d roll %0d yaw %0d pitch %0d",
                     got.kind, got.roll, got.yaw, got.pitch);
        end
    endfunction

    // Offer one byte, wait for the transfer, then record what it should cause
    task automatic offer_byte(input logic [7:0] b, input row_chk_t mode,
                              input axes_t given);
        axes_t r;
        bit    due;
        @(negedge clk);
        if (!(acc_count >= 200 && acc_count < 400) && $urandom_range(99) < 6)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (!in_ready);
        acc_count++;
        due = predict_frame(b, r);
        if (mode == ROW_GIVEN)
            axes_q.push_back(given);
        else if (mode == ROW_PREDICT && due)
            axes_q.push_back(r);
    endtask

    // Stimulus
    initial
    begin
        logic [7:0]  fr [FRAME_LEN];
        logic [15:0] w;
        int          len;
        int          sel;
        bit          drained;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        frm_count  = 4'd0;
        mismatches = 0;
        acc_count  = 0;
        kept_bytes = 0;
        drained    = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            frm_store[i] = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        for (int r = 0; r < 4; r++)
            for (int i = 0; i < DIR_TAB[r].len; i++)
                offer_byte(DIR_TAB[r].bytes[i],
                           (i == DIR_TAB[r].len - 1) ? DIR_TAB[r].chk : ROW_PREDICT,
                           DIR_TAB[r].res);

        // Random frames with noise and the odd truncated frame
        while (kept_bytes < RUN_ITEMS)
        begin
            // Sender pause once until the block has drained
            if (!drained && acc_count >= 800)
            begin
                drained = 1'b1;
                @(negedge clk);
                in_valid = 1'b0;
                while (axes_q.size() != 0)
                    @(negedge clk);
            end
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3))
                    offer_byte(8'($urandom_range(255)), ROW_PREDICT, '0);
            fr[0] = ifp_pkg::HDR_BYTE;
            sel = $urandom_range(99);
            if (sel < 45)
                fr[1] = ifp_pkg::TYPE_RATE;
            else if (sel < 90)
                fr[1] = ifp_pkg::TYPE_ANGLE;
            else if (sel < 95)
                fr[1] = TYPE_ACCEL;
            else
                fr[1] = 8'($urandom_range(255));
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    case ($urandom_range(4))
                        0: w = 16'h8000;
                        1: w = 16'h7FFF;
                        2: w = 16'hFFFF;
                        3: w = 16'h0001;
                        default: w = 16'h0000;
                    endcase
                end
                else
                    w = 16'($urandom_range(16'hFFFF));
                fr[2 + 2 * k] = w[7:0];
                fr[3 + 2 * k] = w[15:8];
            end
            for (int i = 8; i < FRAME_LEN; i++)
                fr[i] = ($urandom_range(9) == 0) ? ifp_pkg::HDR_BYTE : 8'($urandom_range(255));
            len = ($urandom_range(99) < 5) ? $urandom_range(2, FRAME_LEN - 1) : FRAME_LEN;
            for (int i = 0; i < len; i++)
                offer_byte(fr[i], ROW_PREDICT, '0);
        end

        // Drain and finish
        @(negedge clk);
        in_valid = 1'b0;
        while (axes_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && axes_q.size() == 0)
            $display("** imu_frame_parser_top: PASSED **");
        else
            $display("** imu_frame_parser_top: FAILED **");
        $finish;
    end

    // Result side: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && acc_count >= 500)
            begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (acc_count >= 200 && acc_count < 400)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(99) >= 6);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        axes_t got;
        axes_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{kind: kind, roll: roll, yaw: yaw, pitch: pitch};
            if (axes_q.size() == 0)
                log_mismatch("unexpected", '0, got);
            else
            begin
                want = axes_q.pop_front();
                if (got.kind !== want.kind || got.roll !== want.roll ||
                    got.yaw !== want.yaw || got.pitch !== want.pitch)
                    log_mismatch("fields", want, got);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** imu_frame_parser_top: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

[files.f]
hw/rtl/ifp_pkg.sv
hw/rtl/ifp_framer.sv
hw/rtl/ifp_scale.sv
hw/rtl/imu_frame_parser_top.sv
sim/imu_frame_parser_top_test.sv
